/* rtl/mmcn_pkg.sv */
// ----------------------------------------------------------------------------
// mmcn_pkg
// Shared constants for the magnetometer min/max calibration and
// normalisation block: field widths, command codes and output limits.
// ----------------------------------------------------------------------------
package mmcn_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 14;

    localparam int FUNC_W = 3;
    localparam int TICK_W = 32;
    localparam int OUT_W  = 16;
    localparam int AXES   = 3;

    // One extra quotient bit flags saturation beyond the output range
    localparam int Q_BITS = OUT_W + 1;

    localparam logic [TICK_W-1:0] CALIB_TIMEOUT_RST = TICK_W'(60000);

    localparam logic [FUNC_W-1:0] FUNC_SAMPLE   = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_START    = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_STOP     = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FUNC_LOAD_MIN = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FUNC_LOAD_MAX = FUNC_W'(4);

    localparam logic signed [OUT_W-1:0] NORM_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] NORM_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

/* rtl/mmcn_if.sv */
// ----------------------------------------------------------------------------
// mmcn channel interfaces
// Valid/ready channels for sample words, result words and the
// calibration timeout register write.
// ----------------------------------------------------------------------------
interface mmcn_in_if #(
    parameter int SAMPLE_BITS = mmcn_pkg::SAMPLE_BITS_DEF
);
    import mmcn_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [FUNC_W-1:0]             func;
    logic signed [SAMPLE_BITS-1:0] raw_x;
    logic signed [SAMPLE_BITS-1:0] raw_y;
    logic signed [SAMPLE_BITS-1:0] raw_z;
    logic [TICK_W-1:0]             now_ticks;

    modport source (output valid, func, raw_x, raw_y, raw_z, now_ticks, input ready);
    modport sink   (input valid, func, raw_x, raw_y, raw_z, now_ticks, output ready);
endinterface

interface mmcn_out_if;
    import mmcn_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] norm_x;
    logic signed [OUT_W-1:0] norm_y;
    logic signed [OUT_W-1:0] norm_z;
    logic [AXES-1:0]         range_error;
    logic                    save_request;

    modport source (output valid, norm_x, norm_y, norm_z, range_error, save_request,
                    input ready);
    modport sink   (input valid, norm_x, norm_y, norm_z, range_error, save_request,
                    output ready);
endinterface

interface mmcn_cfg_if;
    import mmcn_pkg::*;

    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

/* rtl/mag_minmax_calibrate_normalize.sv */
// ----------------------------------------------------------------------------
// mag_minmax_calibrate_normalize
// Magnetometer hard-iron calibration by per-axis min/max tracking, and
// normalisation of samples to signed Q2.14 against the stored limits.
// ----------------------------------------------------------------------------
// Commands (start, stop, load minima, load maxima) and samples taken while
// calibrating are absorbed and give no result. A sample taken outside
// calibration is normalised axis by axis through one shared restoring
// divider that produces one quotient bit per cycle: each axis with a valid
// range goes through launch, 17 quotient steps and collect, an axis whose
// maximum is not above its minimum is zeroed and flagged without dividing.
// After the last axis the result word enters the output register and the
// input becomes ready for the next word; a previous result still waiting in
// the output register holds that last step until it is taken. The input is
// not ready while a sample is being normalised; a finished result waits in
// the output register while the next word is taken. The timeout register is
// written through the configuration channel, which is always ready.
module mag_minmax_calibrate_normalize #(
    parameter int SAMPLE_BITS = mmcn_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mmcn_pkg::FRAC_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mmcn_cfg_if.sink          i_cfg,
    mmcn_in_if.sink           i_in,
    mmcn_out_if.source        o_out
);
    import mmcn_pkg::*;

    localparam int AxisW = $clog2(AXES);
    localparam logic [AxisW-1:0] AxisLast = AxisW'(AXES - 1);
    localparam logic signed [SAMPLE_BITS-1:0] SampleTop = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SampleBot = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_EMIT} t_state;
    typedef enum logic [1:0] {PH_NONE, PH_CAL, PH_DONE} t_phase;

    t_state                        r_state;
    t_phase                        r_phase;
    logic                          r_req;
    logic [TICK_W-1:0]             r_start_time;
    logic [TICK_W-1:0]             r_timeout;
    logic signed [SAMPLE_BITS-1:0] r_min [AXES];
    logic signed [SAMPLE_BITS-1:0] r_max [AXES];
    logic signed [SAMPLE_BITS-1:0] r_raw [AXES];
    logic [AxisW-1:0]              r_axis;
    logic signed [OUT_W-1:0]       r_norm [AXES];
    logic [AXES-1:0]               r_err;
    logic                          r_save;
    logic                          r_out_valid;
    logic signed [OUT_W-1:0]       r_out_norm [AXES];
    logic [AXES-1:0]               r_out_err;
    logic                          r_out_save;

    logic signed [SAMPLE_BITS-1:0] in_raw [AXES];
    logic signed [SAMPLE_BITS-1:0] n_min [AXES];
    logic signed [SAMPLE_BITS-1:0] n_max [AXES];
    logic signed [SAMPLE_BITS-1:0] seed_min;
    logic signed [SAMPLE_BITS-1:0] seed_max;
    logic [TICK_W-1:0]             elapsed;
    logic                          in_take;
    logic                          axis_ok;
    logic                          div_start;
    logic                          div_done;
    logic signed [OUT_W-1:0]       div_norm;

    assign in_raw[0] = i_in.raw_x;
    assign in_raw[1] = i_in.raw_y;
    assign in_raw[2] = i_in.raw_z;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_take     = i_in.valid && i_in.ready;
    assign elapsed     = i_in.now_ticks - r_start_time;
    assign axis_ok     = r_max[r_axis] > r_min[r_axis];
    assign div_start   = (r_state == S_START) && axis_ok;

    // Widen the limits by a calibrating sample, reseeding on its first one
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            seed_min = (r_phase != PH_CAL) ? SampleTop : r_min[i];
            seed_max = (r_phase != PH_CAL) ? SampleBot : r_max[i];
            n_min[i] = (in_raw[i] < seed_min) ? in_raw[i] : seed_min;
            n_max[i] = (in_raw[i] > seed_max) ? in_raw[i] : seed_max;
        end
    end

    mmcn_divider #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_raw   (r_raw[r_axis]),
        .i_lo    (r_min[r_axis]),
        .i_hi    (r_max[r_axis]),
        .o_done  (div_done),
        .o_norm  (div_norm)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_phase      <= PH_NONE;
            r_req        <= 1'b0;
            r_start_time <= '0;
            r_timeout    <= CALIB_TIMEOUT_RST;
            r_out_valid  <= 1'b0;
            r_axis       <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_min[i] <= SampleBot;
                r_max[i] <= SampleTop;
            end
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_timeout <= i_cfg.data;
            end
            // drop a taken word; the emit step reloads the register itself
            if (o_out.valid && o_out.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        case (i_in.func)
                            FUNC_START: begin
                                r_req        <= 1'b1;
                                r_start_time <= i_in.now_ticks;
                            end
                            FUNC_STOP: begin
                                r_req <= 1'b0;
                            end
                            FUNC_LOAD_MIN: begin
                                for (int i = 0; i < AXES; i++) r_min[i] <= in_raw[i];
                            end
                            FUNC_LOAD_MAX: begin
                                for (int i = 0; i < AXES; i++) r_max[i] <= in_raw[i];
                            end
                            FUNC_SAMPLE: begin
                                if (r_req) begin
                                    r_phase <= PH_CAL;
                                    for (int i = 0; i < AXES; i++) begin
                                        r_min[i] <= n_min[i];
                                        r_max[i] <= n_max[i];
                                    end
                                    if (elapsed >= r_timeout) begin
                                        r_req <= 1'b0;
                                    end
                                end else begin
                                    r_save <= (r_phase == PH_CAL);
                                    if (r_phase == PH_CAL) begin
                                        r_phase <= PH_DONE;
                                    end
                                    for (int i = 0; i < AXES; i++) r_raw[i] <= in_raw[i];
                                    r_err   <= '0;
                                    r_axis  <= '0;
                                    r_state <= S_START;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_START: begin
                    if (axis_ok) begin
                        r_state <= S_WAIT;
                    end else begin
                        // empty range: zero and flag the axis
                        r_norm[r_axis] <= '0;
                        r_err[r_axis]  <= 1'b1;
                        if (r_axis == AxisLast) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_axis <= r_axis + AxisW'(1);
                        end
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_norm[r_axis] <= div_norm;
                        if (r_axis == AxisLast) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_axis  <= r_axis + AxisW'(1);
                            r_state <= S_START;
                        end
                    end
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_norm  <= r_norm;
                        r_out_err   <= r_err;
                        r_out_save  <= r_save;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.norm_x       = r_out_norm[0];
    assign o_out.norm_y       = r_out_norm[1];
    assign o_out.norm_z       = r_out_norm[2];
    assign o_out.range_error  = r_out_err;
    assign o_out.save_request = r_out_save;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (!o_out.range_error[0] || o_out.norm_x == '0)
                     && (!o_out.range_error[1] || o_out.norm_y == '0)
                     && (!o_out.range_error[2] || o_out.norm_z == '0))
        else $error("flagged axis carries a non-zero value");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_WAIT)
        else $error("divider finished outside the wait state");

    a_axis_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START || r_state == S_WAIT) |-> r_axis <= AxisLast)
        else $error("axis counter out of range");

endmodule

/* rtl/mmcn_divider.sv */
// ----------------------------------------------------------------------------
// mmcn_divider
// Restoring divider that normalises one axis: round(2^F*(2*raw-lo-hi)/(hi-lo))
// one quotient bit per cycle, then saturates to the signed output range.
// ----------------------------------------------------------------------------
module mmcn_divider #(
    parameter int SAMPLE_BITS = mmcn_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = mmcn_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [SAMPLE_BITS-1:0]       i_raw,
    input  logic signed [SAMPLE_BITS-1:0]       i_lo,
    input  logic signed [SAMPLE_BITS-1:0]       i_hi,
    output logic                                o_done,
    output logic signed [mmcn_pkg::OUT_W-1:0]   o_norm
);
    import mmcn_pkg::*;

    localparam int NumW  = SAMPLE_BITS + 3;
    localparam int MagW  = SAMPLE_BITS + 2;
    localparam int WideW = (SAMPLE_BITS + FRAC_BITS + 3 > SAMPLE_BITS + Q_BITS + 1)
                         ? SAMPLE_BITS + FRAC_BITS + 3 : SAMPLE_BITS + Q_BITS + 1;
    localparam int CntW  = $clog2(Q_BITS);

    localparam logic [Q_BITS-1:0] QPosMax = Q_BITS'(NORM_MAX);
    localparam logic [Q_BITS-1:0] QNegMax = QPosMax + Q_BITS'(1);

    logic signed [NumW-1:0]  num;
    logic [MagW-1:0]         mag;
    logic [SAMPLE_BITS-1:0]  dif;
    logic [WideW-1:0]        n_rem_init;
    logic [WideW-1:0]        n_den_init;
    logic [WideW-1:0]        rem_sub;
    logic                    take;

    logic                    r_busy;
    logic                    r_done;
    logic [CntW-1:0]         r_cnt;
    logic [WideW-1:0]        r_rem;
    logic [WideW-1:0]        r_den;
    logic [Q_BITS-1:0]       r_q;
    logic                    r_neg;

    always_comb begin
        num = (NumW'(i_raw) <<< 1) - NumW'(i_lo) - NumW'(i_hi);
        mag = num[NumW-1] ? MagW'(-num) : MagW'(num);
        // hi > lo here, so the wrapped difference is the true range
        dif = SAMPLE_BITS'(i_hi - i_lo);
        // dividend 2*mag*2^F + d over divisor 2*d gives round half up
        n_rem_init = (WideW'(mag) << (FRAC_BITS + 1)) + WideW'(dif);
        n_den_init = WideW'(dif) << Q_BITS;
        take       = (r_rem >= r_den);
        rem_sub    = r_rem - r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // pulse once, on the cycle after the last quotient step
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(Q_BITS - 1);
                r_rem  <= n_rem_init;
                r_den  <= n_den_init;
                r_q    <= '0;
                r_neg  <= num[NumW-1];
            end else if (r_busy) begin
                if (take) begin
                    r_rem <= rem_sub;
                end
                r_q   <= {r_q[Q_BITS-2:0], take};
                r_den <= r_den >> 1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - CntW'(1);
                end
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            o_norm = (r_q > QNegMax) ? NORM_MIN : -$signed(r_q[OUT_W-1:0]);
        end else begin
            o_norm = (r_q > QPosMax) ? NORM_MAX : $signed(r_q[OUT_W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule
